[src/rarm_pkg.sv]
// rarm_pkg: shared types and constants for the rational add/multiply/reduce block
// no dependencies
package rarm_pkg;

  localparam int unsigned WideW = 34;
  localparam int unsigned RedW  = 17;
  localparam int unsigned CntW  = 6;

  typedef struct packed {
    logic        op;
    logic [15:0] first_num;
    logic [15:0] first_den;
    logic [15:0] second_num;
    logic [15:0] second_den;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] result_num;
    logic [31:0] result_den;
    logic        zero_gcd_error;
  } out_beat_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD_IN,
    CMD_SEL_A,
    CMD_SEL_B,
    CMD_DIV_REM,
    CMD_DIV_N,
    CMD_DIV_D,
    CMD_STORE_A,
    CMD_STORE_B,
    CMD_MUL1,
    CMD_MUL2,
    CMD_MUL3,
    CMD_SET_ERR,
    CMD_OUT
  } cmd_e;

  typedef enum logic [1:0] {
    TGT_REM,
    TGT_N,
    TGT_D
  } tgt_e;

  typedef struct packed {
    cmd_e op;
  } ctl_cmd_t;

  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic div_done;
    logic out_busy;
  } dp_sts_t;

endpackage

[src/rarm_in_if.sv]
// rarm_in_if: input channel, valid/ready plus one input beat
// depends on rarm_pkg
interface rarm_in_if
  import rarm_pkg::*;
;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/rarm_out_if.sv]
// rarm_out_if: result channel, valid/ready plus one result beat
// depends on rarm_pkg
interface rarm_out_if
  import rarm_pkg::*;
;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/rarm_datapath.sv]
// rarm_datapath: operand registers, shared multiplier, bit-serial signed divider,
// result register; depends on rarm_pkg
module rarm_datapath
  import rarm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctl_cmd_t  cmd_i,
  input  in_beat_t  in_data_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output out_beat_t out_data_o,
  output dp_sts_t   sts_o
);

  logic                    op_q;
  logic signed [RedW-1:0]  an_q, ad_q, bn_q, bd_q;
  logic signed [WideW-1:0] n_q, d_q, a_q, b_q, m1_q, m2_q;
  logic                    err_q;
  logic                    out_valid_q;
  out_beat_t               out_q;

  // divider state
  logic                    busy_q;
  logic [CntW-1:0]         cnt_q;
  logic [WideW:0]          rem_q;
  logic [WideW-1:0]        dq_q;
  logic [WideW-1:0]        dvs_q;
  logic                    rneg_q, qneg_q;
  tgt_e                    tgt_q;

  logic signed [RedW-1:0]  ma, mb;
  logic signed [WideW-1:0] prod;
  logic signed [WideW-1:0] dvd_s, dvs_s;
  logic [WideW:0]          shl, sub;
  logic                    sub_ok;
  logic [WideW:0]          rem_n;
  logic [WideW-1:0]        dq_n;
  logic                    div_last;
  logic [WideW-1:0]        q_fin, r_fin;

  always_comb begin
    ma = an_q;
    mb = bd_q;
    case (cmd_i.op)
      CMD_MUL1: begin ma = an_q; mb = op_q ? bn_q : bd_q; end
      CMD_MUL2: begin ma = ad_q; mb = bn_q; end
      CMD_MUL3: begin ma = ad_q; mb = bd_q; end
      default:  begin ma = an_q; mb = bd_q; end
    endcase
  end
  assign prod = ma * mb;

  always_comb begin
    dvd_s = a_q;
    dvs_s = b_q;
    case (cmd_i.op)
      CMD_DIV_N: begin dvd_s = n_q; dvs_s = a_q; end
      CMD_DIV_D: begin dvd_s = d_q; dvs_s = a_q; end
      default:   begin dvd_s = a_q; dvs_s = b_q; end
    endcase
  end

  // one restoring step on magnitudes
  assign shl      = {rem_q[WideW-1:0], dq_q[WideW-1]};
  assign sub      = shl - {1'b0, dvs_q};
  assign sub_ok   = (shl >= {1'b0, dvs_q});
  assign rem_n    = sub_ok ? sub : shl;
  assign dq_n     = {dq_q[WideW-2:0], sub_ok};
  assign div_last = busy_q && (cnt_q == CntW'(1));
  assign q_fin    = qneg_q ? (~dq_n + 1'b1) : dq_n;
  assign r_fin    = rneg_q ? (~rem_n[WideW-1:0] + 1'b1) : rem_n[WideW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.op == CMD_OUT) out_valid_q <= 1'b1;
      if (cmd_i.op == CMD_DIV_REM || cmd_i.op == CMD_DIV_N || cmd_i.op == CMD_DIV_D) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(WideW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (div_last) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_LOAD_IN: begin
        op_q  <= in_data_i.op;
        an_q  <= {in_data_i.first_num[15], in_data_i.first_num};
        ad_q  <= {in_data_i.first_den[15], in_data_i.first_den};
        bn_q  <= {in_data_i.second_num[15], in_data_i.second_num};
        bd_q  <= {in_data_i.second_den[15], in_data_i.second_den};
        err_q <= 1'b0;
      end
      CMD_SEL_A: begin
        n_q <= WideW'(an_q);
        d_q <= WideW'(ad_q);
        a_q <= WideW'(an_q);
        b_q <= WideW'(ad_q);
      end
      CMD_SEL_B: begin
        n_q <= WideW'(bn_q);
        d_q <= WideW'(bd_q);
        a_q <= WideW'(bn_q);
        b_q <= WideW'(bd_q);
      end
      CMD_DIV_REM, CMD_DIV_N, CMD_DIV_D: begin
        rem_q  <= '0;
        dq_q   <= dvd_s[WideW-1] ? WideW'(-dvd_s) : dvd_s;
        dvs_q  <= dvs_s[WideW-1] ? WideW'(-dvs_s) : dvs_s;
        rneg_q <= dvd_s[WideW-1];
        qneg_q <= dvd_s[WideW-1] ^ dvs_s[WideW-1];
        tgt_q  <= (cmd_i.op == CMD_DIV_REM) ? TGT_REM :
                  (cmd_i.op == CMD_DIV_N) ? TGT_N : TGT_D;
      end
      CMD_STORE_A: begin
        an_q <= n_q[RedW-1:0];
        ad_q <= d_q[RedW-1:0];
      end
      CMD_STORE_B: begin
        bn_q <= n_q[RedW-1:0];
        bd_q <= d_q[RedW-1:0];
      end
      CMD_MUL1: m1_q <= prod;
      CMD_MUL2: m2_q <= prod;
      CMD_MUL3: begin
        n_q <= op_q ? m1_q : m1_q + m2_q;
        a_q <= op_q ? m1_q : m1_q + m2_q;
        d_q <= prod;
        b_q <= prod;
      end
      CMD_SET_ERR: err_q <= 1'b1;
      CMD_OUT: begin
        out_q.result_num     <= err_q ? 32'd0 : n_q[31:0];
        out_q.result_den     <= err_q ? 32'd0 : d_q[31:0];
        out_q.zero_gcd_error <= err_q;
      end
      default: ;
    endcase
    if (busy_q) begin
      rem_q <= rem_n;
      dq_q  <= dq_n;
    end
    if (div_last) begin
      case (tgt_q)
        TGT_REM: begin a_q <= b_q; b_q <= r_fin; end
        TGT_N:   n_q <= q_fin;
        TGT_D:   d_q <= q_fin;
        default: ;
      endcase
    end
  end

  assign sts_o.a_zero   = (a_q == '0);
  assign sts_o.b_zero   = (b_q == '0);
  assign sts_o.div_done = div_last;
  assign sts_o.out_busy = out_valid_q;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

[src/rarm_ctrl.sv]
// rarm_ctrl: sequencer for the three gcd reductions, products and result hand-off
// depends on rarm_pkg
module rarm_ctrl
  import rarm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_sts_t  sts_i,
  output ctl_cmd_t cmd_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StSel   = 4'd1;
  localparam logic [3:0] StChk   = 4'd2;
  localparam logic [3:0] StRem   = 4'd3;
  localparam logic [3:0] StDivN  = 4'd4;
  localparam logic [3:0] StDivD  = 4'd5;
  localparam logic [3:0] StStore = 4'd6;
  localparam logic [3:0] StMul1  = 4'd7;
  localparam logic [3:0] StMul2  = 4'd8;
  localparam logic [3:0] StMul3  = 4'd9;
  localparam logic [3:0] StFin   = 4'd10;
  localparam logic [3:0] StIssD  = 4'd11;

  localparam logic [1:0] WhA = 2'd0;
  localparam logic [1:0] WhB = 2'd1;
  localparam logic [1:0] WhX = 2'd2;

  logic [3:0] state_q, state_d;
  logic [1:0] which_q, which_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d  = state_q;
    which_d  = which_q;
    cmd_o.op = CMD_NONE;
    case (state_q)
      StIdle: if (in_valid_i) begin
        cmd_o.op = CMD_LOAD_IN;
        which_d  = WhA;
        state_d  = StSel;
      end
      StSel: begin
        cmd_o.op = (which_q == WhA) ? CMD_SEL_A : CMD_SEL_B;
        state_d  = StChk;
      end
      StChk: begin
        if (!sts_i.b_zero) begin
          cmd_o.op = CMD_DIV_REM;
          state_d  = StRem;
        end else if (sts_i.a_zero) begin
          // 0/0 somewhere: result is forced to zero
          cmd_o.op = CMD_SET_ERR;
          state_d  = StFin;
        end else begin
          cmd_o.op = CMD_DIV_N;
          state_d  = StDivN;
        end
      end
      StRem: if (sts_i.div_done) state_d = StChk;
      StDivN: if (sts_i.div_done) state_d = StIssD;
      // divider is idle again, start the denominator division
      StIssD: begin
        cmd_o.op = CMD_DIV_D;
        state_d  = StDivD;
      end
      StDivD: if (sts_i.div_done) state_d = StStore;
      StStore: begin
        case (which_q)
          WhA: begin
            cmd_o.op = CMD_STORE_A;
            which_d  = WhB;
            state_d  = StSel;
          end
          WhB: begin
            cmd_o.op = CMD_STORE_B;
            state_d  = StMul1;
          end
          default: state_d = StFin;
        endcase
      end
      StMul1: begin cmd_o.op = CMD_MUL1; state_d = StMul2; end
      StMul2: begin cmd_o.op = CMD_MUL2; state_d = StMul3; end
      StMul3: begin
        cmd_o.op = CMD_MUL3;
        which_d  = WhX;
        state_d  = StChk;
      end
      StFin: if (!sts_i.out_busy) begin
        cmd_o.op = CMD_OUT;
        state_d  = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      which_q <= WhA;
    end else begin
      state_q <= state_d;
      which_q <= which_d;
    end
  end

endmodule

[src/rational_add_mul_reduce_top.sv]
// Rational add/multiply with gcd reduction. One beat in gives one result beat. Each
// input fraction and then the sum or product is reduced by a Euclidean gcd computed
// with a truncating remainder, so signs follow that remainder. Time per beat is
// data dependent: every remainder and every exact division runs on one shared
// bit-serial divider (an issue command, then one restoring step per bit of the 34-bit
// magnitude), and the number of gcd steps depends on the operands. A 0/0 fraction at any
// reduction sets zero_gcd_error and returns zeros. A new beat is taken while the
// previous result still waits at the output register.
// depends on rarm_pkg, rarm_in_if, rarm_out_if, rarm_ctrl, rarm_datapath
module rational_add_mul_reduce_top
  import rarm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rarm_in_if.sink    in_i,
  rarm_out_if.source out_o
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  rarm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rarm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data),
    .sts_o       (sts)
  );

endmodule
